// File: design/c39_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c39_pkg: shared types and constants for the Code 39 start symbol detector
// Event codes, register map, window geometry and the divide-by-five constant.
// ----------------------------------------------------------------------------
package c39_pkg;

  localparam int unsigned MAX_READINGS_DEF = 200;
  localparam int unsigned WIDTH_BITS_DEF   = 16;

  // Nine newest widths are kept; the gap width is the oldest of them,
  // the one that the next shift drops.
  localparam int unsigned WIN_DEPTH = 9;
  localparam int unsigned WIN_IDX_W = $clog2(WIN_DEPTH);

  localparam logic [8:0] START_PATTERN = 9'b010010100;

  localparam int unsigned THR_W = 18;
  localparam int unsigned EVT_W = 3;
  localparam int unsigned PAT_W = 9;
  localparam int unsigned CNT_W = 8;

  // floor(x / 5) for any 32-bit x: (x * DIV5_RECIP) >> DIV5_SHIFT
  localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned DIV5_SHIFT = 34;

  // Configuration port
  localparam int unsigned ADDR_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam logic [ADDR_W-1:0] REG_TIMEOUT_ADDR = 2'd0;
  localparam logic [15:0] TIMEOUT_RST = 16'd3000;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_END     = 3'd2,
    EV_GAP_ERR = 3'd3,
    EV_TIMEOUT = 3'd4,
    EV_LIMIT   = 3'd5
  } event_e;

endpackage

// File: design/code39_start_symbol_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code39_start_symbol_detector: Code 39 start character detection
// Classifies bar/space widths as wide or narrow, finds the start symbol and
// checks the inter-character gap ten widths later.
// ----------------------------------------------------------------------------
//  Channel   | Dir | Payload                                   | Handshake
//  s_axis    | in  | width_ms                                  | tvalid/tready
//  m_axis    | out | event_res, threshold_ms, pattern          | tvalid/tready
//  apb       | in  | timeout limit at byte address 0           | psel/penable
//
//  One cycle per width: the accepted width updates the scan state and the
//  result register at the same edge; a nine-way minimum, the wide/narrow
//  compares and a 32x32 reciprocal multiply for the threshold set the path.
//  The next width is taken while a result waits, as long as m_axis_tready
//  frees the result register in that cycle. Reset clears all scan state and
//  loads the timeout limit with 3000; there is no clearing pass.
// ----------------------------------------------------------------------------
module code39_start_symbol_detector #(
  parameter int unsigned MAX_READINGS = c39_pkg::MAX_READINGS_DEF,
  parameter int unsigned WIDTH_BITS   = c39_pkg::WIDTH_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // width_ms [WIDTH_BITS-1:0], zero padded to whole bytes
  input  logic [((WIDTH_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // event_res [2:0], threshold_ms [20:3], pattern [29:21], zeros [31:30]
  output logic [31:0]                   m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [c39_pkg::ADDR_W-1:0]    paddr,
  input  logic [c39_pkg::DATA_W-1:0]    pwdata,
  output logic [c39_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import c39_pkg::*;

  localparam int unsigned CW = WIDTH_BITS + 4;  // holds 11 * width
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_READINGS);

  logic [15:0]           timeout_q;
  logic [WIDTH_BITS-1:0] win_q [WIN_DEPTH];
  logic [WIDTH_BITS-1:0] win_n [WIN_DEPTH];
  logic [WIDTH_BITS-1:0] mn_q, mn_d, mn_new, mn_eff;
  logic [THR_W-1:0]      thr_q, thr_d, thr_new;
  logic                  scan_q, scan_d, scan_n;
  logic [CNT_W-1:0]      rc_q, rc_d;
  logic [CNT_W-1:0]      gcp_q, gcp_d, gcp_n;
  logic [CNT_W:0]        gcp_sum;
  logic [WIDTH_BITS-1:0] w;
  logic                  in_acc, is_timeout, is_limit, upd, start, gap_hit, gap_wide;
  logic                  clr;
  logic [PAT_W-1:0]      pat;
  logic [63:0]           div_prod;
  logic [33:0]           thr_full;
  logic [CW-1:0]         thr_x11;
  event_e                evt_d;
  logic [PAT_W-1:0]      pat_d;

  logic                  out_valid_q;
  event_e                out_evt_q;
  logic [THR_W-1:0]      out_thr_q;
  logic [PAT_W-1:0]      out_pat_q;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr == REG_TIMEOUT_ADDR) ? DATA_W'(timeout_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready && (paddr == REG_TIMEOUT_ADDR)) begin
      timeout_q <= pwdata[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign w             = s_axis_tdata[WIDTH_BITS-1:0];

  // --------------------------------------------------------------------------
  // Per-width evaluation
  // --------------------------------------------------------------------------
  always_comb begin
    win_n[0] = w;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      win_n[i] = win_q[i-1];
    end
  end

  // Minimum over the shifted window
  always_comb begin
    mn_new = win_n[0];
    for (int i = 1; i < WIN_DEPTH; i++) begin
      if (win_n[i] < mn_new) begin
        mn_new = win_n[i];
      end
    end
  end

  assign is_timeout = 32'(w) >= 32'(timeout_q);
  assign is_limit   = (rc_q > MAX_CNT) || (gcp_q > MAX_CNT);
  assign upd        = (rc_q >= CNT_W'(8)) && !scan_q;
  assign mn_eff     = upd ? mn_new : mn_q;

  // w > floor(11*mn/5) is the same as 5*w > 11*mn for integer w
  assign thr_x11 = CW'(mn_eff) * CW'(11);

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      pat[i] = (CW'(win_n[i]) * CW'(5)) > thr_x11;
    end
  end

  assign gap_wide = (CW'(win_q[WIN_DEPTH-1]) * CW'(5)) > thr_x11;

  // floor(11*mn/5) = 2*mn + floor(mn/5)
  assign div_prod = 64'(32'(mn_new)) * 64'(DIV5_RECIP);
  assign thr_full = {1'b0, 33'(mn_new) << 1} + 34'(div_prod >> DIV5_SHIFT);
  assign thr_new  = thr_full[THR_W-1:0];

  assign start   = upd && (pat == START_PATTERN);
  assign scan_n  = scan_q || start;
  assign gcp_sum = {1'b0, rc_q} + (CNT_W+1)'(10);
  assign gcp_n   = start ? (gcp_sum[CNT_W] ? '1 : gcp_sum[CNT_W-1:0]) : gcp_q;
  assign gap_hit = scan_n && (rc_q == gcp_n);

  always_comb begin
    mn_d   = mn_q;
    thr_d  = thr_q;
    scan_d = scan_n;
    gcp_d  = gcp_n;
    rc_d   = rc_q + CNT_W'(1);
    clr    = 1'b0;
    pat_d  = '0;
    evt_d  = EV_NONE;
    priority if (is_timeout) begin
      clr   = 1'b1;
      evt_d = EV_TIMEOUT;
    end else if (is_limit) begin
      clr   = 1'b1;
      evt_d = EV_LIMIT;
    end else begin
      pat_d = pat;
      if (upd) begin
        mn_d  = mn_new;
        thr_d = thr_new;
      end
      if (gap_hit) begin
        clr   = 1'b1;
        evt_d = gap_wide ? EV_GAP_ERR : EV_END;
      end else if (start) begin
        evt_d = EV_START;
      end
    end
    if (clr) begin
      scan_d = 1'b0;
      gcp_d  = '0;
      rc_d   = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Scan state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= '0;
      end
      mn_q   <= '0;
      thr_q  <= '0;
      scan_q <= 1'b0;
      rc_q   <= '0;
      gcp_q  <= '0;
    end else if (in_acc) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= clr ? '0 : win_n[i];
      end
      mn_q   <= mn_d;
      thr_q  <= thr_d;
      scan_q <= scan_d;
      rc_q   <= rc_d;
      gcp_q  <= gcp_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_evt_q <= evt_d;
      out_thr_q <= thr_d;
      out_pat_q <= pat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_pat_q, out_thr_q, out_evt_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_scan_gap_ahead : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q |-> (rc_q <= gcp_q))
    else $error("gap position passed while scanning");

  a_idle_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !scan_q |-> (gcp_q == '0))
    else $error("gap position set while idle");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= (MAX_CNT + CNT_W'(1)))
    else $error("reading count beyond limit");

  a_start_pattern : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_evt_q == EV_START)) |-> (out_pat_q == START_PATTERN))
    else $error("start reported without start pattern");

  a_reset_pattern : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_evt_q == EV_TIMEOUT) || (out_evt_q == EV_LIMIT)))
      |-> (out_pat_q == '0))
    else $error("pattern not cleared on scan abort");

endmodule
